// ===== design/fmx_pkg.sv =====
// Shared types and constants for the FIFO handoff mutex.
// Request and response beat structs, status codes, waiter store sizes.
// No dependencies.
package fmx_pkg;

  localparam int MAX_THREADS = 16;
  localparam int ID_W        = 4;
  localparam int FIFO_DEPTH  = 16;
  localparam int ADDR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = 4;

  typedef enum logic {
    KIND_LOCK   = 1'b0,
    KIND_UNLOCK = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    STAT_GRANTED         = 3'd0,
    STAT_QUEUED          = 3'd1,
    STAT_ALREADY_OWNER   = 3'd2,
    STAT_ALREADY_WAITING = 3'd3,
    STAT_NOT_OWNER       = 3'd4,
    STAT_FREED           = 3'd5,
    STAT_HANDED_OVER     = 3'd6
  } status_t;

  typedef struct packed {
    kind_t            kind;
    logic [ID_W-1:0]  thread_id;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic             owner_valid;
    logic [ID_W-1:0]  owner_id;
    logic [CNT_W-1:0] waiting_count;
  } rsp_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

endpackage

// ===== design/fmx_wait_mem.sv =====
// Waiter FIFO storage: one write port, one read port, registered read data.
// Depends on fmx_pkg for widths and port structs.
module fmx_wait_mem import fmx_pkg::*; (
  input  logic            clk,
  input  mem_wr_t         wr,
  input  mem_rd_t         rd,
  output logic [ID_W-1:0] rd_data
);

  logic [ID_W-1:0] mem [FIFO_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

// ===== design/fifo_handoff_mutex.sv =====
// Channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall  | in_req  (kind, thread_id)
// out     | out | out_valid/out_stall| out_rsp (status, owner_valid, owner_id, waiting_count)
//
// Requests are taken one at a time; an unlock that hands over to a waiter also
// passes through S_POP for the registered read of the waiter memory head, while in_stall holds off new requests.
// A result register sits on the output, so a new beat is taken while the
// last result waits, unless that result is stalled.
// Reset (rst_n low, synchronous) frees the mutex and empties the waiter queue.
// Depends on fmx_pkg and fmx_wait_mem.
module fifo_handoff_mutex import fmx_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_req,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t out_rsp
);

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  state_t state_r, state_nxt;

  logic                   locked_r, locked_nxt;
  logic [ID_W-1:0]        owner_r, owner_nxt;
  logic [ADDR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [ADDR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [MAX_THREADS-1:0] mask_r, mask_nxt;
  logic                   out_valid_r, out_valid_nxt;
  rsp_t                   out_rsp_r, out_rsp_nxt;

  mem_wr_t         mem_wr;
  mem_rd_t         mem_rd;
  logic [ID_W-1:0] head_id;

  logic accept;
  logic in_range;
  logic out_free;

  fmx_wait_mem u_wait_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd      (mem_rd),
    .rd_data (head_id)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign in_range = int'(in_req.thread_id) < MAX_THREADS;

  always_comb begin
    state_nxt     = state_r;
    locked_nxt    = locked_r;
    owner_nxt     = owner_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    count_nxt     = count_r;
    mask_nxt      = mask_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rsp_nxt   = out_rsp_r;
    mem_wr.en     = 1'b0;
    mem_wr.addr   = wr_ptr_r;
    mem_wr.data   = in_req.thread_id;
    mem_rd.en     = 1'b0;
    mem_rd.addr   = rd_ptr_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt      = 1'b1;
          out_rsp_nxt.status = STAT_NOT_OWNER;
          if (!in_range) begin
            out_rsp_nxt.status = STAT_NOT_OWNER;
          end else if (in_req.kind == KIND_LOCK) begin
            if (!locked_r) begin
              locked_nxt         = 1'b1;
              owner_nxt          = in_req.thread_id;
              out_rsp_nxt.status = STAT_GRANTED;
            end else if (owner_r == in_req.thread_id) begin
              out_rsp_nxt.status = STAT_ALREADY_OWNER;
            end else if (mask_r[in_req.thread_id]) begin
              out_rsp_nxt.status = STAT_ALREADY_WAITING;
            end else begin
              mem_wr.en                    = 1'b1;
              wr_ptr_nxt                   = wr_ptr_r + 1'b1;
              count_nxt                    = count_r + 1'b1;
              mask_nxt[in_req.thread_id]   = 1'b1;
              out_rsp_nxt.status           = STAT_QUEUED;
            end
          end else begin
            if (!locked_r || owner_r != in_req.thread_id) begin
              out_rsp_nxt.status = STAT_NOT_OWNER;
            end else if (count_r == '0) begin
              locked_nxt         = 1'b0;
              owner_nxt          = '0;
              out_rsp_nxt.status = STAT_FREED;
            end else begin
              // head of queue comes back next cycle; result waits for it
              mem_rd.en     = 1'b1;
              out_valid_nxt = 1'b0;
              state_nxt     = S_POP;
            end
          end
          out_rsp_nxt.owner_valid   = locked_nxt;
          out_rsp_nxt.owner_id      = owner_nxt;
          out_rsp_nxt.waiting_count = count_nxt;
        end
      end
      S_POP: begin
        // output register is empty here: it was free when the unlock beat came in
        rd_ptr_nxt                = rd_ptr_r + 1'b1;
        count_nxt                 = count_r - 1'b1;
        mask_nxt[head_id]         = 1'b0;
        owner_nxt                 = head_id;
        out_valid_nxt             = 1'b1;
        out_rsp_nxt.status        = STAT_HANDED_OVER;
        out_rsp_nxt.owner_valid   = 1'b1;
        out_rsp_nxt.owner_id      = head_id;
        out_rsp_nxt.waiting_count = count_r - 1'b1;
        state_nxt                 = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      locked_r    <= 1'b0;
      owner_r     <= '0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      count_r     <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      locked_r    <= locked_nxt;
      owner_r     <= owner_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      count_r     <= count_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// ===== bench/fmx_scoreboard.sv =====
// Response checker for fifo_handoff_mutex: tracks lock ownership and the waiter queue.
// Predicts one response per accepted request beat and compares it with the response channel.
// Depends on fmx_pkg.
module fmx_scoreboard import fmx_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_stall,
  input  req_t in_req,
  input  logic out_valid,
  input  logic out_stall,
  input  rsp_t out_rsp,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic                   lock_held;
  logic [ID_W-1:0]        lock_owner;
  logic [MAX_THREADS-1:0] waiter_mask;
  logic [ID_W-1:0]        waiter_q[$];
  rsp_t                   rsp_q[$];

  // Applies one request to the lock state and returns the response it should produce.
  function automatic rsp_t next_response(req_t r);
    rsp_t p;
    logic [ID_W-1:0] id;
    id = r.thread_id;
    p = '0;
    if (int'(id) >= MAX_THREADS) begin
      p.status = STAT_NOT_OWNER;
    end else if (r.kind == KIND_LOCK) begin
      if (!lock_held) begin
        lock_held  = 1'b1;
        lock_owner = id;
        p.status   = STAT_GRANTED;
      end else if (lock_owner == id) begin
        p.status = STAT_ALREADY_OWNER;
      end else if (waiter_mask[id]) begin
        p.status = STAT_ALREADY_WAITING;
      end else begin
        waiter_q.push_back(id);
        waiter_mask[id] = 1'b1;
        p.status = STAT_QUEUED;
      end
    end else begin
      if (!lock_held || lock_owner != id) begin
        p.status = STAT_NOT_OWNER;
      end else if (waiter_q.size() == 0) begin
        lock_held  = 1'b0;
        lock_owner = '0;
        p.status   = STAT_FREED;
      end else begin
        // ownership passes straight to the oldest waiter; lock stays held
        lock_owner = waiter_q.pop_front();
        waiter_mask[lock_owner] = 1'b0;
        p.status = STAT_HANDED_OVER;
      end
    end
    p.owner_valid   = lock_held;
    p.owner_id      = lock_held ? lock_owner : '0;
    p.waiting_count = CNT_W'(waiter_q.size());
    return p;
  endfunction

  task automatic check_field(string fname, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      lock_held   = 1'b0;
      lock_owner  = '0;
      waiter_mask = '0;
      waiter_q.delete();
      rsp_q.delete();
    end else begin
      if (in_valid && !in_stall)
        rsp_q.push_back(next_response(in_req));
      if (out_valid && !out_stall) begin
        if (rsp_q.size() == 0) begin
          $error("response beat with no request outstanding");
          fail_count++;
        end else begin
          want = rsp_q.pop_front();
          check_field("status", 8'(want.status), 8'(out_rsp.status));
          check_field("owner_valid", 8'(want.owner_valid), 8'(out_rsp.owner_valid));
          check_field("owner_id", 8'(want.owner_id), 8'(out_rsp.owner_id));
          check_field("waiting_count", 8'(want.waiting_count), 8'(out_rsp.waiting_count));
        end
      end
    end
    pending = rsp_q.size();
  end

endmodule

// ===== bench/fifo_handoff_mutex_tb.sv =====
// Top-level bench for fifo_handoff_mutex: clock, reset, request stimulus, response stalls.
// Prediction and comparison live in fmx_scoreboard. Depends on fmx_pkg, fmx_scoreboard.
module fifo_handoff_mutex_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fmx_pkg::*;

  localparam int RANDOM_BEATS = 600;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  req_t in_req;
  logic out_valid;
  logic out_stall;
  rsp_t out_rsp;

  int fail_count;
  int pending;
  int cycle_cnt;
  int stall_hold;
  bit quiet_in;

  fifo_handoff_mutex u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  fmx_scoreboard u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_rsp    (out_rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("fifo_handoff_mutex_tb: FAIL");
      $finish;
    end
  end

  // Response backpressure: short runs of either level, occasional long stalls,
  // and now and then a long open stretch.
  always @(posedge clk) begin
    int r;
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_stall  <= 1'b0;
        stall_hold <= $urandom_range(0, 5);
      end else if (r < 85) begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(0, 2);
      end else if (r < 95) begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(10, 40);
      end else begin
        out_stall  <= 1'b0;
        stall_hold <= $urandom_range(50, 200);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_in || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_beat(kind_t k, logic [ID_W-1:0] id);
    int gap;
    req_t r;
    gap = pick_gap();
    r.kind = k;
    r.thread_id = id;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    kind_t k;
    int pool;
    int base;
    int lock_pct;
    int burst;
    int sent;
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_req     = '0;
    out_stall  = 1'b0;
    stall_hold = 0;
    cycle_cnt  = 0;
    quiet_in   = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: unlock on a free lock, grant, owner relock, free, then fill the
    // waiter queue to its 15-deep limit, repeat waiter, stray unlock, handover
    send_beat(KIND_UNLOCK, 4'd15);
    send_beat(KIND_LOCK, 4'd0);
    send_beat(KIND_LOCK, 4'd0);
    send_beat(KIND_UNLOCK, 4'd0);
    send_beat(KIND_LOCK, 4'd15);
    for (int t = 0; t < 15; t++)
      send_beat(KIND_LOCK, ID_W'(t));
    send_beat(KIND_LOCK, 4'd3);
    send_beat(KIND_UNLOCK, 4'd7);
    send_beat(KIND_UNLOCK, 4'd15);

    // random bursts: small thread pools make owner unlocks and handovers
    // common, the full pool builds deep queues
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      case ($urandom_range(0, 3))
        0:       pool = 2;
        1:       pool = 3;
        2:       pool = 5;
        default: pool = MAX_THREADS;
      endcase
      base     = $urandom_range(0, MAX_THREADS - 1);
      lock_pct = $urandom_range(30, 80);
      burst    = $urandom_range(10, 60);
      quiet_in = ($urandom_range(0, 3) == 0);
      repeat (burst) begin
        if ($urandom_range(0, 99) < lock_pct)
          k = KIND_LOCK;
        else
          k = KIND_UNLOCK;
        send_beat(k, ID_W'((base + $urandom_range(0, pool - 1)) % MAX_THREADS));
        sent++;
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("fifo_handoff_mutex_tb: PASS");
    else
      $display("fifo_handoff_mutex_tb: FAIL");
    $finish;
  end

endmodule
